// ----- design/rms_pkg.sv -----
// ----------------------------------------------------------------------------
// rms_pkg
// Shared constants, codes and the cell control word of the running median
// store.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MEDIAN = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic                     ins_en;
    logic                     pop_en;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         pop_idx;
  } cell_ctl_t;

endpackage

// ----- design/rms_cell.sv -----
// ----------------------------------------------------------------------------
// rms_cell
// One slot of the sorted chain: holds a value, compares it with the new
// word and shifts left or right with its neighbors.
// ----------------------------------------------------------------------------
module rms_cell (
  input  logic                                 clk,
  input  logic [rms_pkg::IDX_W-1:0]            cell_idx,
  input  rms_pkg::cell_ctl_t                   ctl,
  input  logic signed [rms_pkg::DATA_W-1:0]    left_data,
  input  logic                                 left_before,
  input  logic signed [rms_pkg::DATA_W-1:0]    right_data,
  output logic signed [rms_pkg::DATA_W-1:0]    data,
  output logic                                 ins_here,
  output logic signed [rms_pkg::DATA_W-1:0]    tap
);

  logic signed [rms_pkg::DATA_W-1:0] data_r;
  logic signed [rms_pkg::DATA_W-1:0] data_nxt;
  logic [rms_pkg::CNT_W-1:0]         my_pos;
  logic                              occupied;

  assign my_pos   = rms_pkg::CNT_W'(cell_idx);
  assign occupied = my_pos < ctl.count;
  // New word belongs at or before this slot; empty slots count as after it
  assign ins_here = !occupied || (ctl.value < data_r);
  assign data     = data_r;
  assign tap      = (my_pos == ctl.pop_idx) ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_en && ins_here) begin
      data_nxt = left_before ? left_data : ctl.value;
    end else if (ctl.pop_en && (my_pos >= ctl.pop_idx)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- design/running_median_store_unit.sv -----
// ----------------------------------------------------------------------------
// running_median_store_unit
// Sorted store of signed words with insert, lower-median pop and clear.
// ----------------------------------------------------------------------------
// Each item is first captured into the command register; then every cell of
// the sorted chain compares against the new value in parallel
// and shifts one place toward or away from its neighbor. The result sits in
// an output register, so the next word is taken while it waits; a further
// word stalls while a command is held.
// Pop returns the element of rank ceil(count/2); entries above the count are
// never read and need no clearing after reset.
module running_median_store_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic signed [rms_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rms_pkg::DATA_W-1:0] out_median,
  output logic [1:0]                        out_status
);

  localparam int N = rms_pkg::CAPACITY;

  logic                              busy_r, busy_nxt;
  logic [1:0]                        cmd_r;
  logic signed [rms_pkg::DATA_W-1:0] val_r;
  logic [rms_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [rms_pkg::DATA_W-1:0] median_r, median_nxt;
  logic [1:0]                        status_r, status_nxt;

  logic                              fire;
  logic                              full;
  logic                              empty;
  rms_pkg::cell_ctl_t                ctl;
  logic signed [rms_pkg::DATA_W-1:0] median_sel;

  logic signed [rms_pkg::DATA_W-1:0] cell_data [N];
  logic                              cell_before [N];
  logic signed [rms_pkg::DATA_W-1:0] cell_tap [N];

  assign in_stall   = busy_r;
  assign out_valid  = out_valid_r;
  assign out_median = median_r;
  assign out_status = status_r;

  assign fire  = busy_r && (!out_valid_r || !out_stall);
  assign full  = (count_r == rms_pkg::CNT_W'(N));
  assign empty = (count_r == '0);

  always_comb begin
    ctl.value   = val_r;
    ctl.count   = count_r;
    ctl.pop_idx = (count_r - rms_pkg::CNT_W'(1)) >> 1;
    ctl.ins_en  = fire && (cmd_r == rms_pkg::CMD_INSERT) && !full;
    ctl.pop_en  = fire && (cmd_r == rms_pkg::CMD_POP) && !empty;
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic signed [rms_pkg::DATA_W-1:0] l_data;
      logic                              l_before;
      logic signed [rms_pkg::DATA_W-1:0] r_data;
      if (gi == 0) begin : g_first
        assign l_data   = '0;
        assign l_before = 1'b0;
      end else begin : g_mid
        assign l_data   = cell_data[gi-1];
        assign l_before = cell_before[gi-1];
      end
      if (gi == N - 1) begin : g_last
        assign r_data = cell_data[gi];
      end else begin : g_inner
        assign r_data = cell_data[gi+1];
      end
      rms_cell u_cell (
        .clk         (clk),
        .cell_idx    (rms_pkg::IDX_W'(gi)),
        .ctl         (ctl),
        .left_data   (l_data),
        .left_before (l_before),
        .right_data  (r_data),
        .data        (cell_data[gi]),
        .ins_here    (cell_before[gi]),
        .tap         (cell_tap[gi])
      );
    end
  endgenerate

  // Only the cell at the pop index drives a nonzero tap
  always_comb begin
    median_sel = '0;
    for (int i = 0; i < N; i++) begin
      median_sel = median_sel | cell_tap[i];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    median_nxt    = median_r;
    status_nxt    = status_r;
    if (in_valid && !in_stall) begin
      busy_nxt = 1'b1;
    end
    if (fire) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      median_nxt    = '0;
      status_nxt    = rms_pkg::ST_OK;
      unique case (cmd_r)
        rms_pkg::CMD_INSERT: begin
          if (full) begin
            status_nxt = rms_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + rms_pkg::CNT_W'(1);
          end
        end
        rms_pkg::CMD_POP: begin
          if (empty) begin
            status_nxt = rms_pkg::ST_EMPTY;
          end else begin
            median_nxt = median_sel;
            status_nxt = rms_pkg::ST_MEDIAN;
            count_nxt  = count_r - rms_pkg::CNT_W'(1);
          end
        end
        rms_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          // unused command: no change
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
    end
    median_r <= median_nxt;
    status_r <= status_nxt;
  end

endmodule

// ----- design/rms_chk.sv -----
// ----------------------------------------------------------------------------
// rms_chk
// Port-level checks for the running median store, bound to the top level.
// ----------------------------------------------------------------------------
module rms_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [rms_pkg::DATA_W-1:0] out_median,
  input logic [1:0]                        out_status
);

  // Median field is zero on every status but a given median
  a_median_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != rms_pkg::ST_MEDIAN)) |-> (out_median == '0))
    else $error("median nonzero without median status");

  // A taken word stalls the input side once it is captured
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held after accepted word");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_median) && $stable(out_status)))
    else $error("stalled result changed");

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("not idle after reset");

endmodule

bind running_median_store_unit rms_chk u_rms_chk (.*);
